/* src/qvr_pkg.sv */
// Shared types and constants for the quaternion vector rotation block.
package qvr_pkg;

  // Configuration register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    RegQuatW = 2'd0,
    RegQuatX = 2'd1,
    RegQuatY = 2'd2,
    RegQuatZ = 2'd3
  } reg_idx_t;

  localparam int AddrWidth = 4;
  localparam logic signed [15:0] QuatWReset = 16'sd16384;

  // Quaternion in signed Q1.14.
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  // Rotation matrix coefficient in Q2.28; the off-diagonal terms reach 2^32.
  typedef logic signed [33:0] coef_t;

  // Number of register stages from the quaternion registers to the matrix.
  localparam logic [1:0] MatLatency = 2'd2;

  // Saturation bounds of a Q16.16 result.
  localparam logic signed [31:0] RotMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RotMin = -32'sh7FFF_FFFF - 32'sd1;

  // Load enables of the three arithmetic stages of a row.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

/* src/qvr_regs.sv */
// Configuration registers for the quaternion behind an APB-style port.
module qvr_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qvr_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output qvr_pkg::quat_t                 quat,
  output logic                           cfg_wr
);

  qvr_pkg::reg_idx_t idx;
  logic signed [15:0] rd_val;

  assign idx    = qvr_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.w <= qvr_pkg::QuatWReset;
      quat.x <= 16'sd0;
      quat.y <= 16'sd0;
      quat.z <= 16'sd0;
    end else if (cfg_wr) begin
      case (idx)
        qvr_pkg::RegQuatW: quat.w <= pwdata[15:0];
        qvr_pkg::RegQuatX: quat.x <= pwdata[15:0];
        qvr_pkg::RegQuatY: quat.y <= pwdata[15:0];
        qvr_pkg::RegQuatZ: quat.z <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      qvr_pkg::RegQuatW: rd_val = quat.w;
      qvr_pkg::RegQuatX: rd_val = quat.x;
      qvr_pkg::RegQuatY: rd_val = quat.y;
      qvr_pkg::RegQuatZ: rd_val = quat.z;
      default:           rd_val = 16'sd0;
    endcase
  end

  // Registers read back sign-extended to the bus width.
  assign prdata = {{16{rd_val[15]}}, rd_val};

endmodule

/* src/qvr_matrix.sv */
// Two-stage build of the 3x3 rotation matrix from the quaternion registers.
module qvr_matrix (
  input  logic            clk,
  input  logic            rst,
  input  qvr_pkg::quat_t  quat,
  input  logic            cfg_wr,
  output qvr_pkg::coef_t  mat [3][3],
  output logic            busy
);

  logic signed [31:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic [1:0] cnt;

  // First stage: the ten pairwise products.
  always_ff @(posedge clk) begin
    ww <= quat.w * quat.w;
    xx <= quat.x * quat.x;
    yy <= quat.y * quat.y;
    zz <= quat.z * quat.z;
    xy <= quat.x * quat.y;
    wz <= quat.w * quat.z;
    xz <= quat.x * quat.z;
    wy <= quat.w * quat.y;
    yz <= quat.y * quat.z;
    wx <= quat.w * quat.x;
  end

  // Second stage: combine the products into the expanded q v q* matrix.
  always_ff @(posedge clk) begin
    mat[0][0] <= 34'(ww) + 34'(xx) - 34'(yy) - 34'(zz);
    mat[0][1] <= (34'(xy) - 34'(wz)) <<< 1;
    mat[0][2] <= (34'(xz) + 34'(wy)) <<< 1;
    mat[1][0] <= (34'(xy) + 34'(wz)) <<< 1;
    mat[1][1] <= 34'(ww) - 34'(xx) + 34'(yy) - 34'(zz);
    mat[1][2] <= (34'(yz) - 34'(wx)) <<< 1;
    mat[2][0] <= (34'(xz) - 34'(wy)) <<< 1;
    mat[2][1] <= (34'(yz) + 34'(wx)) <<< 1;
    mat[2][2] <= 34'(ww) - 34'(xx) - 34'(yy) + 34'(zz);
  end

  // The matrix is stale until a new quaternion has passed both stages.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      cnt <= qvr_pkg::MatLatency;
    end else if (cnt != 2'd0) begin
      cnt <= cnt - 2'd1;
    end
  end

  assign busy = (cnt != 2'd0);

endmodule

/* src/qvr_row.sv */
// One matrix row times the vector: split products, sums, rounding, clamp.
module qvr_row (
  input  logic                clk,
  input  qvr_pkg::stage_en_t  en,
  input  qvr_pkg::coef_t      coef [3],
  input  logic signed [31:0]  vec [3],
  output logic signed [31:0]  rot,
  output logic                sat
);

  localparam logic signed [67:0] RoundHalf = 68'sd1 <<< 27;

  logic signed [15:0] vh [3];
  logic signed [16:0] vl [3];
  logic signed [49:0] ph [3];
  logic signed [50:0] pl [3];
  logic signed [51:0] hi;
  logic signed [52:0] lo;
  logic signed [67:0] total;
  logic signed [39:0] rnd;

  // Each 32-bit component splits into a signed upper half and an unsigned
  // lower half so that no multiplier is wider than 34 by 17 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vh[i] = vec[i][31:16];
      vl[i] = {1'b0, vec[i][15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < 3; i++) begin
        ph[i] <= coef[i] * vh[i];
        pl[i] <= coef[i] * vl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      hi <= 52'(ph[0]) + 52'(ph[1]) + 52'(ph[2]);
      lo <= 53'(pl[0]) + 53'(pl[1]) + 53'(pl[2]);
    end
  end

  // Exact Q18.44 sum, rounded to nearest with ties toward plus infinity.
  assign total = (68'(hi) <<< 16) + 68'(lo) + RoundHalf;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      rnd <= 40'(total >>> 28);
    end
  end

  always_comb begin
    if (rnd > 40'(qvr_pkg::RotMax)) begin
      rot = qvr_pkg::RotMax;
      sat = 1'b1;
    end else if (rnd < 40'(qvr_pkg::RotMin)) begin
      rot = qvr_pkg::RotMin;
      sat = 1'b1;
    end else begin
      rot = rnd[31:0];
      sat = 1'b0;
    end
  end

endmodule

/* src/quaternion_vector_rotate.sv */
// Top level of the quaternion vector rotation pipeline.
//
// The block rotates a stream of 3D vectors (signed Q16.16) by the quaternion
// held in four configuration registers (signed Q1.14, at byte addresses 0, 4,
// 8 and 12 for w, x, y and z). Each result is q v q* expanded as a matrix
// product, scaled by |q|^2 when q is not of unit length, rounded to Q16.16
// and clamped to the 32-bit range; saturated flags a clamped component.
// An input transfer takes place at a clock edge with in_valid high and
// in_stall low; an output transfer likewise with out_valid and out_stall.
// Throughput is one vector per cycle while neither a stall nor a matrix
// rebuild holds the flow. A result passes a multiplier stage, a sum stage
// and a rounding stage before the output register. Each stage holds its
// item only while the stage ahead is full, so a stalled receiver fills the
// pipeline before in_stall rises, and no item is lost or repeated.
// After reset the quaternion is the identity and the pipeline is empty.
// After reset and after every register write the matrix is rebuilt, during
// which in_stall stays high; registers are to be written only while no
// transfer is in flight, which the block itself does not enforce.
module quaternion_vector_rotate (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qvr_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             vec_x,
  input  logic signed [31:0]             vec_y,
  input  logic signed [31:0]             vec_z,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             rot_x,
  output logic signed [31:0]             rot_y,
  output logic signed [31:0]             rot_z,
  output logic                           saturated
);

  qvr_pkg::quat_t     quat;
  qvr_pkg::coef_t     mat [3][3];
  qvr_pkg::stage_en_t en;
  logic               cfg_wr;
  logic               busy;
  logic               v1, v2, v3;
  logic               en_out;
  logic               in_xfer;
  logic signed [31:0] vec [3];
  logic signed [31:0] rot [3];
  logic [2:0]         sat;

  qvr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quat    (quat),
    .cfg_wr  (cfg_wr)
  );

  qvr_matrix u_matrix (
    .clk    (clk),
    .rst    (rst),
    .quat   (quat),
    .cfg_wr (cfg_wr),
    .mat    (mat),
    .busy   (busy)
  );

  // A stage loads when it is empty or when the stage ahead of it moves on.
  assign en_out = !out_valid || !out_stall;
  assign en.s3  = !v3 || en_out;
  assign en.s2  = !v2 || en.s3;
  assign en.s1  = !v1 || en.s2;

  // No transfer is taken while the matrix is being rebuilt.
  assign in_stall = !en.s1 || busy;
  assign in_xfer  = in_valid && !in_stall;

  assign vec[0] = vec_x;
  assign vec[1] = vec_y;
  assign vec[2] = vec_z;

  for (genvar k = 0; k < 3; k++) begin : g_row
    qvr_row u_row (
      .clk  (clk),
      .en   (en),
      .coef (mat[k]),
      .vec  (vec),
      .rot  (rot[k]),
      .sat  (sat[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= in_xfer;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en_out) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      rot_x     <= rot[0];
      rot_y     <= rot[1];
      rot_z     <= rot[2];
      saturated <= |sat;
    end
  end

`ifndef SYNTH
  // A register write must hold off the input for the matrix rebuild.
  a_wr_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> in_stall)
    else $error("input not held off after a register write");

  // An item in the last arithmetic stage reaches the output when it can move.
  a_s3_to_out: assert property (@(posedge clk) disable iff (rst)
    (v3 && en_out) |=> out_valid)
    else $error("item lost between rounding stage and output");

  // A stalled full output with a full pipeline must stall the input.
  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && v3 && v2 && v1) |-> in_stall)
    else $error("input taken while every stage is full");

  // The saturation flag implies some component sits at a bound.
  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (rot_x == qvr_pkg::RotMax || rot_x == qvr_pkg::RotMin ||
       rot_y == qvr_pkg::RotMax || rot_y == qvr_pkg::RotMin ||
       rot_z == qvr_pkg::RotMax || rot_z == qvr_pkg::RotMin))
    else $error("saturated set with no component at a bound");
`endif

endmodule

/* tb/tb_quaternion_vector_rotate.sv */
// Self-checking testbench for the quaternion vector rotation block.
module tb_quaternion_vector_rotate;

  // One rotated vector as it leaves the block.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } rot_t;

  // Holds the quaternion that software last wrote and the rotated vectors
  // still owed by the block, oldest first.
  class rotation_checker;
    logic signed [15:0] qw, qx, qy, qz;
    rot_t expected_rot[$];
    int errors;

    function new();
      qw = qvr_pkg::QuatWReset;
      qx = '0;
      qy = '0;
      qz = '0;
      errors = 0;
    endfunction

    function void load_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      qw = w;
      qx = x;
      qy = y;
      qz = z;
    endfunction

    // Expanded q v q* as an exact integer matrix in Q2.28, applied to the
    // vector, rounded half up to Q16.16 and clamped to 32 bits.
    function rot_t rotate_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                                 logic signed [31:0] vz);
      longint w, x, y, z;
      longint coef[3][3];
      longint v[3];
      logic signed [71:0] acc, cw, vw;
      logic signed [31:0] comp[3];
      rot_t res;
      w = qw;
      x = qx;
      y = qy;
      z = qz;
      coef[0][0] = w*w + x*x - y*y - z*z;
      coef[0][1] = 2 * (x*y - w*z);
      coef[0][2] = 2 * (x*z + w*y);
      coef[1][0] = 2 * (x*y + w*z);
      coef[1][1] = w*w - x*x + y*y - z*z;
      coef[1][2] = 2 * (y*z - w*x);
      coef[2][0] = 2 * (x*z - w*y);
      coef[2][1] = 2 * (y*z + w*x);
      coef[2][2] = w*w - x*x - y*y + z*z;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      res.sat = 1'b0;
      for (int r = 0; r < 3; r++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          cw = coef[r][k];
          vw = v[k];
          acc = acc + cw * vw;
        end
        acc = (acc + (72'sd1 <<< 27)) >>> 28;
        if (acc > 72'sd2147483647) begin
          comp[r] = qvr_pkg::RotMax;
          res.sat = 1'b1;
        end else if (acc < -72'sd2147483648) begin
          comp[r] = qvr_pkg::RotMin;
          res.sat = 1'b1;
        end else begin
          comp[r] = acc[31:0];
        end
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      return res;
    endfunction

    function void note_vector(logic signed [31:0] vx, logic signed [31:0] vy,
                              logic signed [31:0] vz);
      expected_rot.push_back(rotate_vector(vx, vy, vz));
    endfunction

    function void compare_field(string name, longint expv, longint actv);
      if (expv != actv) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        errors++;
      end
    endfunction

    function void check_rotation(logic signed [31:0] ax, logic signed [31:0] ay,
                                 logic signed [31:0] az, logic asat);
      rot_t e;
      if (expected_rot.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %0d %0d %0d %0d",
                 $time, ax, ay, az, asat);
        errors++;
        return;
      end
      e = expected_rot.pop_front();
      compare_field("rot_x", e.x, ax);
      compare_field("rot_y", e.y, ay);
      compare_field("rot_z", e.z, az);
      compare_field("saturated", e.sat, asat);
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [qvr_pkg::AddrWidth-1:0]  paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [31:0]             vec_x;
  logic signed [31:0]             vec_y;
  logic signed [31:0]             vec_z;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [31:0]             rot_x;
  logic signed [31:0]             rot_y;
  logic signed [31:0]             rot_z;
  logic                           saturated;

  // When set, neither the sender nor the receiver idles.
  logic                           quiet;
  int                             stall_left;
  rotation_checker                rot_chk;

  quaternion_vector_rotate i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog. This bound lies far beyond the slowest correct run, so it
  // only trips when the block hangs.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // The receiver stalls in short random bursts, which let the pipeline fill
  // up behind the stall so that in_stall has to rise.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 3) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Both channels are sampled at the rising edge, before any of this edge's
  // updates land, so a transfer is seen exactly as the block sees it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rot_chk.note_vector(vec_x, vec_y, vec_z);
      end
      if (out_valid && !out_stall) begin
        rot_chk.check_rotation(rot_x, rot_y, rot_z, saturated);
      end
    end
  end

  // Drops valid and waits until every owed result has come back, then
  // lets the pipeline settle. The first edge makes sure a transfer taken
  // at the current edge has been noted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rot_chk.expected_rot.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: a setup cycle, then an access cycle that completes
  // at the edge where pready is high. The upper half of pwdata is noise that
  // the block must ignore.
  task automatic write_reg(qvr_pkg::reg_idx_t idx, logic signed [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Quaternion changes only happen with the pipeline empty. The block holds
  // in_stall high while it rebuilds the matrix, so no vector can slip in
  // against the old coefficients.
  task automatic set_quat(logic signed [15:0] w, logic signed [15:0] x,
                          logic signed [15:0] y, logic signed [15:0] z);
    drain();
    write_reg(qvr_pkg::RegQuatW, w);
    write_reg(qvr_pkg::RegQuatX, x);
    write_reg(qvr_pkg::RegQuatY, y);
    write_reg(qvr_pkg::RegQuatZ, z);
    rot_chk.load_quat(w, x, y, z);
  endtask

  // Presents one vector and returns at the edge where it is taken. A short
  // gap with valid low is inserted now and then.
  task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    if (!quiet && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    vec_x    <= x;
    vec_y    <= y;
    vec_z    <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A vector component: full-range noise, small values that rarely clip,
  // or one of the corner values.
  function automatic logic signed [31:0] pick_component();
    int sel;
    int s;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return $urandom;
    end else if (sel < 8) begin
      s = int'($urandom_range(0, 2097152)) - 1048576;
      return s;
    end else begin
      case ($urandom_range(0, 5))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sd0;
        3: return 32'sd1;
        4: return -32'sd1;
        default: return 32'sh0001_0000;
      endcase
    end
  endfunction

  // A batch of random vectors; with pause set, the sender stops halfway and
  // waits for every result before going on.
  task automatic send_random(int count, bit pause);
    for (int i = 0; i < count; i++) begin
      if (pause && i == count / 2) begin
        drain();
      end
      send_vector(pick_component(), pick_component(), pick_component());
    end
  endtask

  initial begin
    rot_chk  = new();
    rst      = 1'b1;
    quiet    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    vec_x    = '0;
    vec_y    = '0;
    vec_z    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset quaternion is the identity, so every vector must come back as
    // it went in, corners included.
    send_vector(32'sd0, 32'sd0, 32'sd0);
    send_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vector(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_vector(32'sd1, -32'sd1, 32'sh0001_0000);
    send_vector(-32'sd1, 32'sd1, -32'sh0001_0000);
    send_vector(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    send_vector(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
    send_vector(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0);
    send_random(60, 1'b0);

    // A tiny scalar part makes the diagonal a single LSB of Q2.28, so the
    // rounding lands exactly on halves: ties must go toward plus infinity.
    set_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_vector(32'sh0800_0000, -32'sh0800_0000, 32'sh1800_0000);
    send_vector(-32'sh1800_0000, 32'sh07FF_FFFF, -32'sh0800_0001);
    send_vector(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0800_0001);
    send_vector(32'sh0800_0001, 32'sh0000_0001, -32'sh07FF_FFFF);
    send_random(30, 1'b0);

    // Largest and smallest register values: a far from unit quaternion
    // scales the result up and clips it.
    set_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_random(70, 1'b1);
    set_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_random(70, 1'b0);

    // Scalar part of -2.0: a pure scale by four, clipping from 2^29 up and below -2^29.
    set_quat(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_vector(32'sh2000_0000, -32'sh2000_0000, 32'sh1FFF_FFFF);
    send_vector(-32'sh2000_0001, 32'sh2000_0001, 32'sh7FFF_FFFF);
    send_random(50, 1'b0);

    // A quarter turn about z, run back to back with no idling on either side.
    set_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    quiet <= 1'b1;
    send_random(80, 1'b0);
    drain();
    quiet <= 1'b0;

    // Random quaternions over the full register range.
    for (int p = 0; p < 4; p++) begin
      set_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      send_random(75, p == 0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (rot_chk.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/qvr_pkg.sv
src/qvr_regs.sv
src/qvr_matrix.sv
src/qvr_row.sv
src/quaternion_vector_rotate.sv
tb/tb_quaternion_vector_rotate.sv
